// ===== sv/apa_pkg.sv =====
// apa_pkg: shared types, codes and helpers of the address pool allocator.
// Used by apa_ctrl, apa_dpath and address_pool_allocator; depends on nothing.
package apa_pkg;

    // Default pool window size in addresses
    localparam int POOL_SIZE_DEF = 256;

    // Bitmap rows: 32 flags per row, offset bits below ROW_LSB select the flag
    localparam int ROW_W   = 32;
    localparam int ROW_LSB = 5;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_END   = 1'b1;

    // Request kinds; the fourth code is unused
    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_QUERY   = 2'd2
    } kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EXHAUSTED = 2'd1,
        STAT_OUTSIDE   = 2'd2
    } status_t;

    // Request beat
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
    } in_item_t;

    // Result beat
    typedef struct packed {
        logic [31:0] granted_address;
        logic        in_use;
        logic [1:0]  status;
    } out_item_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FRESH_CHK,
        S_ROW_RD,
        S_ROW_MOD,
        S_RESP
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    accept;      // capture request, reset scan row
        logic    scan_rd;     // read bitmap row at scan counter
        logic    scan_next;   // advance scan counter
        logic    take_rel;    // pick lowest released flag of current row
        logic    take_fresh;  // pick fresh offset and bump it
        logic    row_rd;      // read bitmap row of captured offset
        logic    row_mod;     // write back updated row, set result
        logic    res_load;    // set result to zero fields with res_sel status
        status_t res_sel;
        logic    out_load;    // move result into output register
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [1:0] kind;
        logic       win_ok;
        logic       found;
        logic       last_row;
        logic       fresh_ok;
        logic       out_free;
    } sts_t;

    // Index of the lowest set bit of a row (zero when the row is empty)
    function automatic logic [ROW_LSB-1:0] lowest_bit(input logic [ROW_W-1:0] row);
        logic [ROW_W-1:0]   iso;
        logic [ROW_LSB-1:0] idx;
        iso = row & (~row + ROW_W'(1));
        idx = '0;
        for (int i = 0; i < ROW_W; i++) begin
            idx = idx | ({ROW_LSB{iso[i]}} & ROW_LSB'(i));
        end
        return idx;
    endfunction

endpackage

// ===== sv/apa_ctrl.sv =====
// apa_ctrl: request sequencer of the address pool allocator.
// Depends on apa_pkg; drives apa_dpath through cmd_t and reads sts_t.
module apa_ctrl
    import apa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (sts.kind == KIND_ALLOC)
                begin
                    state_next = S_SCAN_RD;
                end
                else if ((sts.kind == KIND_RELEASE || sts.kind == KIND_QUERY) && sts.win_ok)
                begin
                    state_next = S_ROW_RD;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (sts.found)
                begin
                    state_next = S_ROW_MOD;
                end
                else if (sts.last_row)
                begin
                    state_next = S_FRESH_CHK;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_FRESH_CHK:
            begin
                state_next = sts.fresh_ok ? S_ROW_RD : S_RESP;
            end
            S_ROW_RD:
            begin
                state_next = S_ROW_MOD;
            end
            S_ROW_MOD:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd          = '0;
        cmd.res_sel  = STAT_OK;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            S_DISPATCH:
            begin
                if (sts.kind == KIND_RELEASE || sts.kind == KIND_QUERY)
                begin
                    if (!sts.win_ok)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = STAT_OUTSIDE;
                    end
                end
                else if (sts.kind != KIND_ALLOC)
                begin
                    // unused kind: all-zero result
                    cmd.res_load = 1'b1;
                end
            end
            S_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
            end
            S_SCAN_CHK:
            begin
                if (sts.found)
                begin
                    cmd.take_rel = 1'b1;
                end
                else if (!sts.last_row)
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_FRESH_CHK:
            begin
                if (sts.fresh_ok)
                begin
                    cmd.take_fresh = 1'b1;
                end
                else
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = STAT_EXHAUSTED;
                end
            end
            S_ROW_RD:
            begin
                cmd.row_rd = 1'b1;
            end
            S_ROW_MOD:
            begin
                cmd.row_mod = 1'b1;
            end
            S_RESP:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // An accepted request always goes to dispatch next
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_DISPATCH)
        else $error("accepted request did not reach dispatch");

    // Row update only follows a row read or a successful scan check
    a_mod_source: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROW_MOD |->
            $past(state_reg) == S_ROW_RD || $past(state_reg) == S_SCAN_CHK)
        else $error("row update without preceding read");

    // Scan check always has read data from the previous cycle
    a_scan_pair: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN_CHK |-> $past(state_reg) == S_SCAN_RD)
        else $error("scan check without scan read");

endmodule

// ===== sv/apa_dpath.sv =====
// apa_dpath: bitmap memory, offsets, fresh pointer and result register.
// Depends on apa_pkg; commanded by apa_ctrl.
module apa_dpath
    import apa_pkg::*;
#(
    parameter int POOL_SIZE = POOL_SIZE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [31:0] start_address,
    input  logic [31:0] end_address,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item
);

    localparam int ROWS   = (POOL_SIZE + ROW_W - 1) / ROW_W;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int OFFX_W = ROW_AW + ROW_LSB;
    localparam int FR_W   = $clog2(POOL_SIZE + 1);

    // Each row: released flags in the upper half, in-use flags in the lower
    logic [2*ROW_W-1:0] mem [ROWS];

    logic [1:0]         kind_reg;
    logic               win_ok_reg;
    logic [OFFX_W-1:0]  off_reg;
    logic [ROW_AW-1:0]  row_cnt_reg;
    logic [FR_W-1:0]    fresh_reg;
    logic [2*ROW_W-1:0] rdata_reg;
    logic               rvld_reg;
    logic [ROWS-1:0]    row_vld_reg;
    logic [31:0]        res_granted_reg;
    logic               res_in_use_reg;
    status_t            res_status_reg;
    logic               out_valid_reg;
    out_item_t          out_item_reg;

    logic [31:0]        diff;
    logic               win;
    logic [ROW_AW-1:0]  off_row;
    logic [ROW_LSB-1:0] bit_sel;
    logic [ROW_AW-1:0]  rd_addr;
    logic               mem_re;
    logic [ROW_W-1:0]   rel_row;
    logic [ROW_W-1:0]   use_row;
    logic [ROW_W-1:0]   rel_new;
    logic [ROW_W-1:0]   use_new;
    logic               fresh_ok;
    logic               out_free;

    // Window test on the incoming address
    assign diff = in_item.address - start_address;
    assign win  = diff < 32'(POOL_SIZE);

    assign off_row = off_reg[OFFX_W-1:ROW_LSB];
    assign bit_sel = off_reg[ROW_LSB-1:0];
    assign rd_addr = cmd.scan_rd ? row_cnt_reg : off_row;
    assign mem_re  = cmd.scan_rd | cmd.row_rd;

    // Rows never written read as cleared
    assign rel_row = rvld_reg ? rdata_reg[2*ROW_W-1:ROW_W] : '0;
    assign use_row = rvld_reg ? rdata_reg[ROW_W-1:0] : '0;

    // Fresh address must lie in the window and not above the end address
    assign fresh_ok = (fresh_reg < FR_W'(POOL_SIZE)) &&
                      ({1'b0, start_address} + 33'(fresh_reg) <= {1'b0, end_address});

    assign out_free = !out_valid_reg || out_ready;

    // Row update per request kind
    always_comb
    begin
        rel_new = rel_row;
        use_new = use_row;
        unique case (kind_reg)
            KIND_ALLOC:
            begin
                rel_new[bit_sel] = 1'b0;
                use_new[bit_sel] = 1'b1;
            end
            KIND_RELEASE:
            begin
                rel_new[bit_sel] = 1'b1;
                use_new[bit_sel] = 1'b0;
            end
            default:
            begin
                rel_new = rel_row;
                use_new = use_row;
            end
        endcase
    end

    // Status to controller
    always_comb
    begin
        sts.kind     = kind_reg;
        sts.win_ok   = win_ok_reg;
        sts.found    = |rel_row;
        sts.last_row = row_cnt_reg == ROW_AW'(ROWS - 1);
        sts.fresh_ok = fresh_ok;
        sts.out_free = out_free;
    end

    // Bitmap memory: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.row_mod)
        begin
            mem[off_row] <= {rel_new, use_new};
        end
        if (mem_re)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Request capture and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg   <= in_item.kind;
            win_ok_reg <= win;
            off_reg    <= OFFX_W'(diff);
        end
        else if (cmd.take_rel)
        begin
            off_reg <= {row_cnt_reg, lowest_bit(rel_row)};
        end
        else if (cmd.take_fresh)
        begin
            off_reg <= OFFX_W'(fresh_reg);
        end

        if (cmd.res_load)
        begin
            res_granted_reg <= '0;
            res_in_use_reg  <= 1'b0;
            res_status_reg  <= cmd.res_sel;
        end
        else if (cmd.row_mod)
        begin
            res_granted_reg <= (kind_reg == KIND_ALLOC) ? start_address + 32'(off_reg) : '0;
            res_in_use_reg  <= (kind_reg == KIND_QUERY) ? use_row[bit_sel] : 1'b0;
            res_status_reg  <= STAT_OK;
        end

        if (cmd.out_load)
        begin
            out_item_reg.granted_address <= res_granted_reg;
            out_item_reg.in_use          <= res_in_use_reg;
            out_item_reg.status          <= res_status_reg;
        end
    end

    // Control state: scan counter, fresh pointer, row valid bits, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg   <= '0;
            fresh_reg     <= '0;
            rvld_reg      <= 1'b0;
            row_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                row_cnt_reg <= '0;
            end
            else if (cmd.scan_next)
            begin
                row_cnt_reg <= row_cnt_reg + ROW_AW'(1);
            end
            if (cmd.take_fresh)
            begin
                fresh_reg <= fresh_reg + FR_W'(1);
            end
            if (mem_re)
            begin
                rvld_reg <= row_vld_reg[rd_addr];
            end
            if (cmd.row_mod)
            begin
                row_vld_reg[off_row] <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Fresh pointer stops at the window size
    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= FR_W'(POOL_SIZE))
        else $error("fresh pointer beyond window");

    // A released pick needs a non-empty row
    a_take_rel: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_rel |-> |rel_row)
        else $error("released pick from empty row");

    // A fresh pick needs a fresh address in range
    a_take_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_fresh |-> fresh_ok)
        else $error("fresh pick while exhausted");

    // Result only moves into a free output register
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_valid_reg || out_ready)
        else $error("output register overwritten");

endmodule

// ===== sv/address_pool_allocator.sv =====
// address_pool_allocator: top level; configuration registers, sequencer and datapath.
// Depends on apa_pkg, apa_ctrl and apa_dpath.
//
//   channel | signals                       | direction | beat
//   --------+-------------------------------+-----------+--------------------------
//   in      | in_valid in_ready in_item     | to block  | kind, address
//   out     | out_valid out_ready out_item  | from block| granted_address, in_use, status
//   cfg     | cfg_valid cfg_ready cfg_index | to block  | register index, cfg_data
//
// One request at a time. Outside-window release/query and unused kinds go from dispatch
// straight to the response; in-window release/query read and rewrite one bitmap row.
// Allocate scans the released bitmap one 32-flag row at a time through the single memory
// read port, stopping at the lowest released address, else takes a fresh address.
// Reset clears per-row valid bits at once; no clearing pass. A result waits in the
// output register while out_ready is low; the next request is taken after it moves there.
module address_pool_allocator
    import apa_pkg::*;
#(
    parameter int POOL_SIZE = POOL_SIZE_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    logic [31:0] start_reg;
    logic [31:0] end_reg;
    cmd_t        cmd;
    sts_t        sts;

    // Configuration registers, written at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            end_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_START: start_reg <= cfg_data;
                REG_END:   end_reg   <= cfg_data;
                default:   start_reg <= start_reg;
            endcase
        end
    end

    // Sequencer
    apa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath
    apa_dpath #(
        .POOL_SIZE (POOL_SIZE)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .start_address (start_reg),
        .end_address   (end_reg),
        .in_item       (in_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_item      (out_item)
    );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for address_pool_allocator: directed table, then random phases.
// Depends on apa_pkg and the address_pool_allocator RTL; needs nothing else to run.
`timescale 1ns / 1ps

module testbench;
    import apa_pkg::*;

    localparam int POOL_SIZE = POOL_SIZE_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 30;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_item_t             in_item;
    logic                 out_valid;
    logic                 out_ready;
    out_item_t            out_item;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    address_pool_allocator #(
        .POOL_SIZE(POOL_SIZE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item(out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Directed stimulus row: a register write or a request beat
    typedef struct {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [31:0]          data;
        bit                   typed;
        in_item_t             beat;
        out_item_t            want;
    } plan_row_t;

    // Shadow of the allocator state
    logic [POOL_SIZE-1:0] held_flags  = '0;
    logic [POOL_SIZE-1:0] freed_flags = '0;
    int                   next_fresh  = 0;
    logic [31:0]          pool_start  = '0;
    logic [31:0]          pool_last   = '0;

    out_item_t awaited_responses[$];
    out_item_t want_beat;
    plan_row_t plan[$];

    int errors        = 0;
    int beats_sent    = 0;
    int beats_checked = 0;
    int regs_written  = 0;
    int settings_used = 1;
    int burst_left    = 0;
    int holds_asked   = 0;
    int holds_done    = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Expected response of the pool to one request; updates the shadow state
    function automatic out_item_t pool_response(in_item_t beat);
        out_item_t   r;
        logic [31:0] off;
        int          lo;
        r   = '0;
        lo  = -1;
        off = beat.address - pool_start;
        case (beat.kind)
            KIND_ALLOC:
            begin
                for (int i = 0; i < POOL_SIZE; i++)
                    if (freed_flags[i] && lo < 0)
                        lo = i;
                if (lo >= 0)
                begin
                    freed_flags[lo]   = 1'b0;
                    held_flags[lo]    = 1'b1;
                    r.granted_address = pool_start + 32'(lo);
                end
                else if (next_fresh >= POOL_SIZE ||
                         {1'b0, pool_start} + 33'(next_fresh) > {1'b0, pool_last})
                    r.status = STAT_EXHAUSTED;
                else
                begin
                    held_flags[next_fresh]  = 1'b1;
                    freed_flags[next_fresh] = 1'b0;
                    r.granted_address       = pool_start + 32'(next_fresh);
                    next_fresh++;
                end
            end
            KIND_RELEASE:
            begin
                if (off >= POOL_SIZE)
                    r.status = STAT_OUTSIDE;
                else
                begin
                    held_flags[off]  = 1'b0;
                    freed_flags[off] = 1'b1;
                end
            end
            KIND_QUERY:
            begin
                if (off >= POOL_SIZE)
                    r.status = STAT_OUTSIDE;
                else
                    r.in_use = held_flags[off];
            end
            default: ;
        endcase
        return r;
    endfunction

    // Random address: mostly inside the window, releases biased toward held slots
    function automatic logic [31:0] pick_address(bit prefer_held);
        int sel;
        int base;
        sel  = $urandom_range(0, 99);
        base = $urandom_range(0, POOL_SIZE - 1);
        if (prefer_held && sel < 60)
            for (int i = 0; i < POOL_SIZE; i++)
                if (held_flags[(base + i) % POOL_SIZE])
                    return pool_start + 32'((base + i) % POOL_SIZE);
        if (sel < 75)
            return pool_start + 32'(base);
        if (sel < 88)
            return pool_start + 32'($urandom_range(0, POOL_SIZE + 64));
        return $urandom;
    endfunction

    function automatic plan_row_t beat_row(logic [1:0] kind, logic [31:0] addr);
        plan_row_t p;
        p              = '{default: '0};
        p.beat.kind    = kind;
        p.beat.address = addr;
        return p;
    endfunction

    function automatic plan_row_t typed_row(logic [1:0] kind, logic [31:0] addr,
                                            logic [31:0] grant, logic used,
                                            logic [1:0] stat);
        plan_row_t p;
        p                      = beat_row(kind, addr);
        p.typed                = 1'b1;
        p.want.granted_address = grant;
        p.want.in_use          = used;
        p.want.status          = stat;
        return p;
    endfunction

    function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        plan_row_t p;
        p         = '{default: '0};
        p.is_reg  = 1'b1;
        p.reg_idx = idx;
        p.data    = data;
        return p;
    endfunction

    // Offer one request beat; sender works in bursts with idle gaps between them
    task automatic offer_beat(in_item_t beat, bit typed, out_item_t want);
        out_item_t predicted;
        in_valid <= 1'b1;
        in_item  <= beat;
        do @(posedge clk); while (!in_ready);
        predicted = pool_response(beat);
        awaited_responses.push_back(typed ? want : predicted);
        beats_sent++;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(0, 15);
        end
        else
            burst_left--;
    endtask

    // Hold input low until every response is back, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (awaited_responses.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_START)
            pool_start = data;
        else
            pool_last = data;
        regs_written++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // New pool setting, written while the block is idle
    task automatic set_pool(logic [31:0] first, logic [31:0] last);
        wait_idle();
        write_reg(REG_START, first);
        write_reg(REG_END, last);
        settings_used++;
    endtask

    // Random phase: kind mix weighted by alloc_pct, a few unused-kind beats
    task automatic run_phase(int n, int alloc_pct);
        in_item_t  beat;
        out_item_t none;
        int        roll;
        none = '0;
        for (int k = 0; k < n; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < alloc_pct)
                beat.kind = KIND_ALLOC;
            else if (roll < alloc_pct + (97 - alloc_pct) / 2)
                beat.kind = KIND_RELEASE;
            else if (roll < 97)
                beat.kind = KIND_QUERY;
            else
                beat.kind = KIND_UNUSED;
            beat.address = (beat.kind == KIND_ALLOC) ? $urandom
                                                     : pick_address(beat.kind == KIND_RELEASE);
            offer_beat(beat, 1'b0, none);
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch: expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Response checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_responses.size() == 0)
            begin
                $display("%0t ns: response beat with none expected: %h", $time, out_item);
                errors++;
            end
            else
            begin
                want_beat = awaited_responses.pop_front();
                check_field("granted_address", want_beat.granted_address,
                            out_item.granted_address);
                check_field("in_use", 32'(want_beat.in_use), 32'(out_item.in_use));
                check_field("status", 32'(want_beat.status), 32'(out_item.status));
                beats_checked++;
            end
        end
    end

    // Receiver: repeating stall pattern, rerolled now and then; long hold-off on request
    initial
    begin
        int hold_left;
        int pat_left;
        int pat_period;
        int pat_stall;
        int pat_phase;
        hold_left  = 0;
        pat_left   = 0;
        pat_period = 1;
        pat_stall  = 0;
        pat_phase  = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (holds_done != holds_asked)
            begin
                out_ready <= 1'b0;
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            else
            begin
                if (pat_left == 0)
                begin
                    pat_period = $urandom_range(1, 8);
                    pat_stall  = $urandom_range(0, pat_period - 1);
                    pat_left   = $urandom_range(8, 60);
                end
                pat_left--;
                pat_phase = (pat_phase + 1) % pat_period;
                out_ready <= (pat_phase >= pat_stall);
            end
        end
    end

    // Main sequence
    initial
    begin
        logic [31:0] first;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_START;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset pool is the single address zero
        plan.push_back(typed_row(KIND_ALLOC,   32'hFFFF_FFFF, 32'h0, 1'b0, STAT_OK));
        plan.push_back(typed_row(KIND_ALLOC,   32'h0,         32'h0, 1'b0, STAT_EXHAUSTED));
        plan.push_back(typed_row(KIND_QUERY,   32'h0,         32'h0, 1'b1, STAT_OK));
        plan.push_back(typed_row(KIND_QUERY,   32'h100,       32'h0, 1'b0, STAT_OUTSIDE));
        plan.push_back(typed_row(KIND_QUERY,   32'hFFFF_FFFF, 32'h0, 1'b0, STAT_OUTSIDE));
        plan.push_back(typed_row(KIND_RELEASE, 32'h12C,       32'h0, 1'b0, STAT_OUTSIDE));
        plan.push_back(typed_row(KIND_UNUSED,  32'hFFFF_FFFF, 32'h0, 1'b0, STAT_OK));
        // Release of a slot never handed out, then lowest-released selection
        plan.push_back(typed_row(KIND_RELEASE, 32'hFF,        32'h0, 1'b0, STAT_OK));
        plan.push_back(typed_row(KIND_RELEASE, 32'h0,         32'h0, 1'b0, STAT_OK));
        plan.push_back(typed_row(KIND_QUERY,   32'h0,         32'h0, 1'b0, STAT_OK));
        plan.push_back(typed_row(KIND_ALLOC,   32'h0,         32'h0, 1'b0, STAT_OK));
        plan.push_back(typed_row(KIND_ALLOC,   32'h0,         32'hFF, 1'b0, STAT_OK));
        plan.push_back(typed_row(KIND_ALLOC,   32'h0,         32'h0, 1'b0, STAT_EXHAUSTED));
        plan.push_back(typed_row(KIND_QUERY,   32'hFF,        32'h0, 1'b1, STAT_OK));
        plan.push_back(reg_row(REG_END, 32'hFFFF_FFFF));
        plan.push_back(typed_row(KIND_ALLOC,   32'h0,         32'h1, 1'b0, STAT_OK));
        // Start moved near the top: maps kept, window wraps past zero
        plan.push_back(reg_row(REG_START, 32'hFFFF_FF80));
        plan.push_back(beat_row(KIND_ALLOC, 32'h0));
        plan.push_back(beat_row(KIND_QUERY, 32'hFFFF_FF80));
        plan.push_back(beat_row(KIND_QUERY, 32'h0000_007F));
        plan.push_back(beat_row(KIND_QUERY, 32'h0000_0080));
        // Fresh address would pass the top of the address space
        plan.push_back(reg_row(REG_START, 32'hFFFF_FFFF));
        plan.push_back(beat_row(KIND_ALLOC, 32'h0));
        plan.push_back(beat_row(KIND_RELEASE, 32'h0000_00FE));
        plan.push_back(beat_row(KIND_ALLOC, 32'h0));

        foreach (plan[i])
        begin
            if (plan[i].is_reg)
            begin
                wait_idle();
                write_reg(plan[i].reg_idx, plan[i].data);
                settings_used++;
            end
            else
                offer_beat(plan[i].beat, plan[i].typed, plan[i].want);
        end

        // Small pool bounded by the end register
        first = $urandom;
        set_pool(first, first + 32'($urandom_range(10, 60)));
        run_phase(100, 45);

        // Whole address space, allocate-heavy to run the fresh pointer out
        set_pool(32'h0, 32'hFFFF_FFFF);
        run_phase(200, 85);

        // Window straddling the top of the address space
        set_pool(32'hFFFF_FFFF - 32'($urandom_range(0, 100)), 32'hFFFF_FFFF);
        run_phase(80, 45);

        // Arbitrary start and end
        set_pool($urandom, $urandom);
        run_phase(80, 45);

        // Long receiver hold-off while requests keep coming
        set_pool(32'h0, 32'h0);
        holds_asked++;
        run_phase(40, 40);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (awaited_responses.size() != 0)
        begin
            $display("%0t ns: %0d response beats never arrived", $time,
                     awaited_responses.size());
            errors++;
        end

        $display("Covered %0d request beats and %0d register writes over %0d pool settings,",
                 beats_sent, regs_written, settings_used);
        $display("%0d responses compared; fresh pointer reached %0d of %0d.",
                 beats_checked, next_fresh, POOL_SIZE);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/apa_pkg.sv
sv/apa_ctrl.sv
sv/apa_dpath.sv
sv/address_pool_allocator.sv
sim/testbench.sv
